### sv/sglcd_pkg.sv
// sglcd_pkg: shared types and constants for the scaled glyph to lcd byte generator
// holds the beat payload structs, opcodes, panel commands and header byte indexes
// no dependencies
package sglcd_pkg;

    // default sizing
    localparam int GLYPH_COUNT_DEF = 96;
    localparam int MAX_SCALE_DEF   = 3;

    // font rows per glyph and first printable code
    localparam int            ROWS_PER_GLYPH = 8;
    localparam logic [7:0]    FIRST_CODE     = 8'h20;

    // input opcodes
    localparam logic [1:0] OP_FONT_WRITE = 2'd0;
    localparam logic [1:0] OP_START      = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    // panel commands
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2a;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2b;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2c;

    // header byte positions
    localparam logic [3:0] HDR_COL_CMD  = 4'd0;
    localparam logic [3:0] HDR_XS_HI    = 4'd1;
    localparam logic [3:0] HDR_XS_LO    = 4'd2;
    localparam logic [3:0] HDR_XE_HI    = 4'd3;
    localparam logic [3:0] HDR_XE_LO    = 4'd4;
    localparam logic [3:0] HDR_ROW_CMD  = 4'd5;
    localparam logic [3:0] HDR_YS_HI    = 4'd6;
    localparam logic [3:0] HDR_YS_LO    = 4'd7;
    localparam logic [3:0] HDR_YE_HI    = 4'd8;
    localparam logic [3:0] HDR_YE_LO    = 4'd9;
    localparam logic [3:0] HDR_WR_CMD   = 4'd10;

    // input beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  font_address;
        logic [7:0]  font_value;
        logic [7:0]  char_code;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [1:0]  scale;
        logic [15:0] fg_colour;
        logic [15:0] bg_colour;
    } sglcd_in_t;

    // output beat
    typedef struct packed {
        logic        dc_flag;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] next_x;
    } sglcd_out_t;

endpackage

### sv/scaled_glyph_to_lcd_bytes.sv
// scaled_glyph_to_lcd_bytes: top level of the glyph to panel byte stream generator
// font rows live in an on-chip synchronous ram, registered ahead of pixel selection
// depends on sglcd_pkg
//
//  channel  | ports                          | direction | carries
//  ---------+--------------------------------+-----------+-------------------------------
//  input    | s_valid s_ready s_payload      | in        | font write, glyph start, tick
//  result   | m_valid m_ready m_payload      | out       | one panel byte per busy tick
//
// one beat per cycle on both sides unless m_ready stalls the result channel;
// each tick's byte passes the pixel stage (font ram read), then the output register
// a glyph takes 11 header ticks plus 128*scale*scale pixel ticks
// reset clears the sequencer and both valid stages; the font ram is not cleared
// s_ready drops only while pixel stage and output register are full and m_ready is low
module scaled_glyph_to_lcd_bytes
    import sglcd_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sglcd_in_t  s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output sglcd_out_t m_payload
);

    localparam int FONT_DEPTH = GLYPH_COUNT * ROWS_PER_GLYPH;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_HEADER = 3'b010,
        ST_PIXELS = 3'b100
    } state_t;

    // sequencer state
    state_t      state_reg, state_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        half_reg, half_next;
    logic [1:0]  sub_col_reg, sub_col_next;
    logic [1:0]  sub_row_reg, sub_row_next;
    logic [2:0]  dot_col_reg, dot_col_next;
    logic [2:0]  dot_row_reg, dot_row_next;

    // latched glyph settings
    logic [1:0]  zoom_reg;
    logic [7:0]  glyph_reg;
    logic        blank_reg;
    logic [15:0] x_reg, y_reg, x_end_reg, y_end_reg, next_x_reg;
    logic [15:0] ink_reg, paper_reg;

    // pixel stage
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_hdr_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_dc_reg;
    logic        s1_last_reg;
    logic [15:0] s1_next_x_reg;
    logic [2:0]  s1_bit_sel_reg;
    logic        s1_blank_reg;
    logic [7:0]  s1_ink_b_reg, s1_paper_b_reg;

    // font ram
    logic [7:0]         font_mem [FONT_DEPTH];
    logic [7:0]         font_q_reg;
    logic               font_wr_en, font_rd_en;
    logic [FONT_AW-1:0] font_wr_idx, font_rd_idx;

    // output register
    logic        m_valid_reg, m_valid_next;
    sglcd_out_t  m_payload_reg;

    logic        s_acc, tick_acc, start_acc, m_free, s1_adv;
    logic        pix_last;
    logic [1:0]  zoom_m1;
    logic [1:0]  scale_sat;
    logic [15:0] side_len;
    logic [7:0]  glyph_idx;
    logic        glyph_blank;
    logic [7:0]  hdr_byte;
    logic        hdr_dc;
    sglcd_out_t  s1_out;

    // handshake
    assign m_free    = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && m_free;
    assign s_ready   = !s1_valid_reg || m_free;
    assign s_acc     = s_valid && s_ready;
    assign tick_acc  = s_acc && (s_payload.opcode == OP_TICK) && (state_reg != ST_IDLE);
    assign start_acc = s_acc && (s_payload.opcode == OP_START) && (state_reg == ST_IDLE);

    // start decode: scale clamp, blank glyph detection, extents
    always_comb begin
        scale_sat = (s_payload.scale == 2'd0) ? 2'd1 : s_payload.scale;
        if (32'(scale_sat) > MAX_SCALE) begin
            scale_sat = 2'(MAX_SCALE);
        end
    end
    assign side_len    = {11'd0, scale_sat, 3'b000};
    assign glyph_idx   = s_payload.char_code - FIRST_CODE;
    assign glyph_blank = (s_payload.char_code <= FIRST_CODE) || (32'(glyph_idx) >= GLYPH_COUNT);

    // header byte select
    always_comb begin
        hdr_dc = 1'b1;
        unique case (hdr_cnt_reg)
            HDR_COL_CMD: begin
                hdr_dc   = 1'b0;
                hdr_byte = CMD_COLUMN_SET;
            end
            HDR_XS_HI:   hdr_byte = x_reg[15:8];
            HDR_XS_LO:   hdr_byte = x_reg[7:0];
            HDR_XE_HI:   hdr_byte = x_end_reg[15:8];
            HDR_XE_LO:   hdr_byte = x_end_reg[7:0];
            HDR_ROW_CMD: begin
                hdr_dc   = 1'b0;
                hdr_byte = CMD_ROW_SET;
            end
            HDR_YS_HI:   hdr_byte = y_reg[15:8];
            HDR_YS_LO:   hdr_byte = y_reg[7:0];
            HDR_YE_HI:   hdr_byte = y_end_reg[15:8];
            HDR_YE_LO:   hdr_byte = y_end_reg[7:0];
            HDR_WR_CMD: begin
                hdr_dc   = 1'b0;
                hdr_byte = CMD_MEMORY_WRITE;
            end
            default:     hdr_byte = 8'd0;
        endcase
    end

    // pixel walk: byte half, replicated column, dot column, replicated row, dot row
    assign zoom_m1  = zoom_reg - 2'd1;
    assign pix_last = half_reg && (sub_col_reg == zoom_m1) && (dot_col_reg == 3'd7)
                      && (sub_row_reg == zoom_m1) && (dot_row_reg == 3'd7);

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        half_next    = half_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        dot_col_next = dot_col_reg;
        dot_row_next = dot_row_reg;
        if (start_acc) begin
            state_next   = ST_HEADER;
            hdr_cnt_next = HDR_COL_CMD;
            half_next    = 1'b0;
            sub_col_next = 2'd0;
            sub_row_next = 2'd0;
            dot_col_next = 3'd0;
            dot_row_next = 3'd0;
        end else if (tick_acc) begin
            unique case (state_reg)
                ST_HEADER: begin
                    hdr_cnt_next = hdr_cnt_reg + 4'd1;
                    if (hdr_cnt_reg == HDR_WR_CMD) begin
                        state_next = ST_PIXELS;
                    end
                end
                ST_PIXELS: begin
                    half_next = !half_reg;
                    if (pix_last) begin
                        state_next = ST_IDLE;
                    end
                    if (half_reg) begin
                        if (sub_col_reg != zoom_m1) begin
                            sub_col_next = sub_col_reg + 2'd1;
                        end else begin
                            sub_col_next = 2'd0;
                            if (dot_col_reg != 3'd7) begin
                                dot_col_next = dot_col_reg + 3'd1;
                            end else begin
                                dot_col_next = 3'd0;
                                if (sub_row_reg != zoom_m1) begin
                                    sub_row_next = sub_row_reg + 2'd1;
                                end else begin
                                    sub_row_next = 2'd0;
                                    dot_row_next = dot_row_reg + 3'd1;
                                end
                            end
                        end
                    end
                end
                default: state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hdr_cnt_reg <= HDR_COL_CMD;
            half_reg    <= 1'b0;
            sub_col_reg <= 2'd0;
            sub_row_reg <= 2'd0;
            dot_col_reg <= 3'd0;
            dot_row_reg <= 3'd0;
        end else begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            half_reg    <= half_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            dot_col_reg <= dot_col_next;
            dot_row_reg <= dot_row_next;
        end
    end

    // glyph settings latched on start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg <= 2'd1;
        end else if (start_acc) begin
            zoom_reg <= scale_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_acc) begin
            glyph_reg  <= glyph_idx;
            blank_reg  <= glyph_blank;
            x_reg      <= s_payload.x_pos;
            y_reg      <= s_payload.y_pos;
            x_end_reg  <= s_payload.x_pos + side_len - 16'd1;
            y_end_reg  <= s_payload.y_pos + side_len - 16'd1;
            next_x_reg <= s_payload.x_pos + side_len;
            ink_reg    <= s_payload.fg_colour;
            paper_reg  <= s_payload.bg_colour;
        end
    end

    // font ram ports
    assign font_wr_en  = s_acc && (s_payload.opcode == OP_FONT_WRITE)
                         && (32'(s_payload.font_address) < FONT_DEPTH);
    assign font_wr_idx = FONT_AW'(s_payload.font_address);
    assign font_rd_en  = tick_acc && (state_reg == ST_PIXELS) && !blank_reg;
    assign font_rd_idx = FONT_AW'({glyph_reg, dot_row_reg});

    always_ff @(posedge aclk) begin
        if (font_wr_en) begin
            font_mem[font_wr_idx] <= s_payload.font_value;
        end
        if (font_rd_en) begin
            font_q_reg <= font_mem[font_rd_idx];
        end
    end

    // pixel stage load
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (tick_acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            s1_hdr_reg     <= (state_reg == ST_HEADER);
            s1_byte_reg    <= hdr_byte;
            s1_dc_reg      <= (state_reg == ST_HEADER) ? hdr_dc : 1'b1;
            s1_last_reg    <= (state_reg == ST_PIXELS) && pix_last;
            s1_next_x_reg  <= ((state_reg == ST_PIXELS) && pix_last) ? next_x_reg : 16'd0;
            s1_bit_sel_reg <= ~dot_col_reg;
            s1_blank_reg   <= blank_reg;
            s1_ink_b_reg   <= half_reg ? ink_reg[7:0] : ink_reg[15:8];
            s1_paper_b_reg <= half_reg ? paper_reg[7:0] : paper_reg[15:8];
        end
    end

    // pixel colour byte from the font row
    always_comb begin
        s1_out.dc_flag = s1_dc_reg;
        s1_out.last    = s1_last_reg;
        s1_out.next_x  = s1_next_x_reg;
        if (s1_hdr_reg) begin
            s1_out.tx_byte = s1_byte_reg;
        end else if (!s1_blank_reg && font_q_reg[s1_bit_sel_reg]) begin
            s1_out.tx_byte = s1_ink_b_reg;
        end else begin
            s1_out.tx_byte = s1_paper_b_reg;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_payload_reg <= s1_out;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### sv/sglcd_checker.sv
// sglcd_checker: port level checks for the glyph byte stream generator
// bound to scaled_glyph_to_lcd_bytes; depends on sglcd_pkg
module sglcd_checker
    import sglcd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input sglcd_in_t  s_payload,
    input logic       m_valid,
    input logic       m_ready,
    input sglcd_out_t m_payload
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // command bytes are only the three panel commands
    a_cmd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.dc_flag |->
            (m_payload.tx_byte == CMD_COLUMN_SET) || (m_payload.tx_byte == CMD_ROW_SET)
            || (m_payload.tx_byte == CMD_MEMORY_WRITE))
        else $error("command byte with unknown code");

    // the final byte of a glyph is pixel data
    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.last |-> m_payload.dc_flag)
        else $error("final glyph byte flagged as command");

    // next_x only carries a value on the final byte
    a_next_x_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.last |-> m_payload.next_x == 16'd0)
        else $error("next_x set on a non-final byte");

endmodule

bind scaled_glyph_to_lcd_bytes sglcd_checker u_sglcd_checker (.*);

### tb/sv/tb_scaled_glyph_to_lcd_bytes.sv
// tb_scaled_glyph_to_lcd_bytes: self-checking bench for the glyph to panel byte generator
// loads the font, drives directed and random beats, predicts every panel byte and checks it
// depends on sglcd_pkg and scaled_glyph_to_lcd_bytes
module tb_scaled_glyph_to_lcd_bytes;
    import sglcd_pkg::*;

    localparam int         FONT_DEPTH = GLYPH_COUNT_DEF * ROWS_PER_GLYPH;
    localparam int         HEADER_LEN = int'(HDR_WR_CMD) + 1;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // glyphs that are loaded and drawn: the first few and the last few printable codes
    localparam int LOW_CODE_FIRST  = 'h21;
    localparam int LOW_CODE_LAST   = 'h24;
    localparam int HIGH_CODE_FIRST = 'h7c;
    localparam int HIGH_CODE_LAST  = 'h7f;

    // glyph stream predictor and expected byte store
    class glyph_stream_scoreboard;
        logic [7:0]  font_rows [FONT_DEPTH];
        bit          busy;
        logic [7:0]  glyph_char;
        logic [15:0] org_x;
        logic [15:0] org_y;
        int unsigned zoom;
        logic [15:0] ink;
        logic [15:0] paper;
        int unsigned byte_idx;
        int unsigned bytes_seen;
        int unsigned fail_count;
        sglcd_out_t  bytes_due[$];

        function new();
            foreach (font_rows[i]) font_rows[i] = 8'h00;
            busy       = 1'b0;
            glyph_char = 8'h00;
            org_x      = 16'h0000;
            org_y      = 16'h0000;
            zoom       = 1;
            ink        = 16'h0000;
            paper      = 16'h0000;
            byte_idx   = 0;
            bytes_seen = 0;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return bytes_due.size();
        endfunction

        // colour of one pixel of the scaled glyph, row-major
        function logic [15:0] dot_colour(int unsigned pixel);
            int unsigned side;
            int unsigned row;
            int unsigned col;
            int unsigned glyph;
            logic [7:0]  dots;
            side = 8 * zoom;
            row  = pixel / side;
            col  = pixel % side;
            // space, control codes and codes past the font are blank
            if (glyph_char <= FIRST_CODE) return paper;
            glyph = glyph_char - FIRST_CODE;
            if (glyph >= GLYPH_COUNT_DEF) return paper;
            dots = font_rows[glyph * ROWS_PER_GLYPH + row / zoom];
            return dots[7 - (col / zoom)] ? ink : paper;
        endfunction

        // next byte of the panel stream, advances the sequencer
        function sglcd_out_t next_panel_byte();
            sglcd_out_t  o;
            logic [15:0] x_end;
            logic [15:0] y_end;
            logic [15:0] colour;
            int unsigned p;
            x_end     = org_x + 16'(8 * zoom - 1);
            y_end     = org_y + 16'(8 * zoom - 1);
            o         = '0;
            o.dc_flag = 1'b1;
            case (byte_idx)
                HDR_COL_CMD: begin
                    o.dc_flag = 1'b0;
                    o.tx_byte = CMD_COLUMN_SET;
                end
                HDR_XS_HI: o.tx_byte = org_x[15:8];
                HDR_XS_LO: o.tx_byte = org_x[7:0];
                HDR_XE_HI: o.tx_byte = x_end[15:8];
                HDR_XE_LO: o.tx_byte = x_end[7:0];
                HDR_ROW_CMD: begin
                    o.dc_flag = 1'b0;
                    o.tx_byte = CMD_ROW_SET;
                end
                HDR_YS_HI: o.tx_byte = org_y[15:8];
                HDR_YS_LO: o.tx_byte = org_y[7:0];
                HDR_YE_HI: o.tx_byte = y_end[15:8];
                HDR_YE_LO: o.tx_byte = y_end[7:0];
                HDR_WR_CMD: begin
                    o.dc_flag = 1'b0;
                    o.tx_byte = CMD_MEMORY_WRITE;
                end
                default: begin
                    // pixels go out high byte first
                    p         = byte_idx - HEADER_LEN;
                    colour    = dot_colour(p / 2);
                    o.tx_byte = p[0] ? colour[7:0] : colour[15:8];
                end
            endcase
            byte_idx++;
            if (byte_idx >= HEADER_LEN + 128 * zoom * zoom) begin
                o.last   = 1'b1;
                o.next_x = org_x + 16'(8 * zoom);
                busy     = 1'b0;
                byte_idx = 0;
            end
            return o;
        endfunction

        // accepted input beat
        function void note_beat(sglcd_in_t b);
            case (b.opcode)
                OP_FONT_WRITE: begin
                    if (b.font_address < FONT_DEPTH) font_rows[b.font_address] = b.font_value;
                end
                OP_START: begin
                    // a start during a glyph is dropped
                    if (!busy) begin
                        if (b.scale == 2'd0) zoom = 1;
                        else if (b.scale > MAX_SCALE_DEF) zoom = MAX_SCALE_DEF;
                        else zoom = b.scale;
                        glyph_char = b.char_code;
                        org_x      = b.x_pos;
                        org_y      = b.y_pos;
                        ink        = b.fg_colour;
                        paper      = b.bg_colour;
                        byte_idx   = 0;
                        busy       = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (busy) bytes_due.push_back(next_panel_byte());
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            if (fail_count < 100) $display("MISMATCH at %0t: %s", $time, msg);
            fail_count++;
        endtask

        // accepted output beat against the oldest expected byte
        task check_byte(sglcd_out_t got);
            sglcd_out_t want;
            bytes_seen++;
            if (bytes_due.size() == 0) begin
                report_mismatch($sformatf("byte %0d: %02h with none expected",
                                          bytes_seen, got.tx_byte));
                return;
            end
            want = bytes_due.pop_front();
            if (got.dc_flag !== want.dc_flag)
                report_mismatch($sformatf("byte %0d: dc_flag %0b want %0b",
                                          bytes_seen, got.dc_flag, want.dc_flag));
            if (got.tx_byte !== want.tx_byte)
                report_mismatch($sformatf("byte %0d: tx_byte %02h want %02h",
                                          bytes_seen, got.tx_byte, want.tx_byte));
            if (got.last !== want.last)
                report_mismatch($sformatf("byte %0d: last %0b want %0b",
                                          bytes_seen, got.last, want.last));
            if (got.next_x !== want.next_x)
                report_mismatch($sformatf("byte %0d: next_x %04h want %04h",
                                          bytes_seen, got.next_x, want.next_x));
        endtask
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    sglcd_in_t  s_payload = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    sglcd_out_t m_payload;

    int unsigned tx_idle_pct = 15;
    int unsigned rx_idle_pct = 68;

    glyph_stream_scoreboard sb = new();

    scaled_glyph_to_lcd_bytes uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #10 aclk = ~aclk;

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result beats
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_byte(m_payload);
    end

    // beat with every field random
    function automatic sglcd_in_t any_beat(logic [1:0] op);
        sglcd_in_t b;
        b.opcode       = op;
        b.font_address = 10'($urandom);
        b.font_value   = 8'($urandom);
        b.char_code    = 8'($urandom);
        b.x_pos        = 16'($urandom);
        b.y_pos        = 16'($urandom);
        b.scale        = 2'($urandom);
        b.fg_colour    = 16'($urandom);
        b.bg_colour    = 16'($urandom);
        return b;
    endfunction

    // one of the loaded printable codes
    function automatic logic [7:0] drawn_code();
        if ($urandom_range(1) == 0) return 8'($urandom_range(LOW_CODE_LAST, LOW_CODE_FIRST));
        return 8'($urandom_range(HIGH_CODE_LAST, HIGH_CODE_FIRST));
    endfunction

    // one input beat, with random sender idles ahead of it
    task automatic send_beat(input sglcd_in_t b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(b);
    endtask

    // every row of one glyph
    task automatic load_glyph(input logic [7:0] ch);
        sglcd_in_t   b;
        int unsigned pick;
        for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
            b              = any_beat(OP_FONT_WRITE);
            b.font_address = 10'(int'(ch - FIRST_CODE) * ROWS_PER_GLYPH + r);
            pick           = $urandom_range(99);
            if (pick < 10) b.font_value = 8'hff;
            else if (pick < 20) b.font_value = 8'h00;
            send_beat(b);
        end
    endtask

    task automatic start_glyph(input logic [7:0] ch, input logic [15:0] x, input logic [15:0] y,
                               input logic [1:0] sc, input logic [15:0] fg,
                               input logic [15:0] bg);
        sglcd_in_t b;
        b           = any_beat(OP_START);
        b.char_code = ch;
        b.x_pos     = x;
        b.y_pos     = y;
        b.scale     = sc;
        b.fg_colour = fg;
        b.bg_colour = bg;
        send_beat(b);
    endtask

    task automatic finish_glyph();
        while (sb.busy) send_beat(any_beat(OP_TICK));
    endtask

    // hold the sender off until every expected byte is out
    task automatic drain_stream();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (sb.pending() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected bytes never came out", sb.pending()));
        repeat (8) @(posedge aclk);
    endtask

    // mostly whole glyphs with random content, some noise in between
    task automatic random_phase(input int unsigned goal);
        sglcd_in_t   b;
        bit          was_busy;
        int unsigned pick;
        int unsigned counted;
        counted = 0;
        while (counted < goal || sb.busy) begin
            was_busy = sb.busy;
            pick     = $urandom_range(99);
            if (!was_busy) begin
                if (pick < 70) begin
                    b    = any_beat(OP_START);
                    pick = $urandom_range(99);
                    // loaded glyphs, space, or codes outside the font
                    if (pick < 60) b.char_code = drawn_code();
                    else if (pick < 70) b.char_code = FIRST_CODE;
                    else if (pick < 85) b.char_code = 8'($urandom_range(8'h1f));
                    else b.char_code = 8'($urandom_range(8'hff, 8'h80));
                    // small scales keep the glyphs short
                    pick    = $urandom_range(99);
                    b.scale = (pick < 20) ? 2'd0 : (pick < 95) ? 2'd1 : 2'd2;
                    if ($urandom_range(9) == 0) b.x_pos = 16'hffff - 16'($urandom_range(24));
                    if ($urandom_range(9) == 0) b.y_pos = 16'hffff - 16'($urandom_range(24));
                end else if (pick < 80) begin
                    b = any_beat(OP_TICK);
                end else if (pick < 88) begin
                    b = any_beat(OP_UNUSED);
                end else begin
                    b = any_beat(OP_FONT_WRITE);
                end
            end else begin
                if (pick < 90) b = any_beat(OP_TICK);
                else if (pick < 94) b = any_beat(OP_FONT_WRITE);
                else if (pick < 97) b = any_beat(OP_START);
                else b = any_beat(OP_UNUSED);
            end
            // only beats that change something count
            if ((b.opcode == OP_FONT_WRITE && b.font_address < FONT_DEPTH) ||
                (b.opcode == OP_START && !was_busy) ||
                (b.opcode == OP_TICK && was_busy))
                counted++;
            send_beat(b);
        end
    endtask

    // main sequence
    initial begin
        sglcd_in_t b;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // load every glyph that is ever drawn, so no unwritten row is read
        for (int c = LOW_CODE_FIRST; c <= LOW_CODE_LAST; c++) load_glyph(8'(c));
        for (int c = HIGH_CODE_FIRST; c <= HIGH_CODE_LAST; c++) load_glyph(8'(c));

        // idle noise and out of range font writes
        send_beat(any_beat(OP_UNUSED));
        send_beat(any_beat(OP_TICK));
        b              = any_beat(OP_FONT_WRITE);
        b.font_address = 10'(FONT_DEPTH);
        send_beat(b);
        b.font_address = 10'h3ff;
        send_beat(b);

        // largest scale with wrapping end coordinates; a font write, a dropped start
        // and noise mid glyph, and the stall pattern changes while it streams
        start_glyph(8'h23, 16'hfff4, 16'hffee, 2'd3, 16'h07e0, 16'h001f);
        repeat (380) send_beat(any_beat(OP_TICK));
        b              = any_beat(OP_FONT_WRITE);
        b.font_address = 10'((8'h23 - FIRST_CODE) * ROWS_PER_GLYPH + 6);
        b.font_value   = 8'ha5;
        send_beat(b);
        send_beat(any_beat(OP_START));
        send_beat(any_beat(OP_UNUSED));

        tx_idle_pct = 68;
        rx_idle_pct = 15;
        repeat (380) send_beat(any_beat(OP_TICK));

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        finish_glyph();
        drain_stream();

        random_phase(120);
        drain_stream();

        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
